/* rtl/wrpb_pkg.sv */
// Shared types and constants for the weight ring percent balancer.
// No dependencies; imported by the controller, the datapath and the top level.
package wrpb_pkg;

	localparam int W_WEIGHT  = 16;
	localparam int W_LIMIT   = 7;
	localparam int W_SLOT    = 4;
	localparam int W_PCT     = 7;
	localparam int W_CUR     = 4;
	localparam int PCT_SCALE = 100;

	// commands from the controller to the datapath
	typedef struct packed {
		logic push;
		logic bal_init;
		logic sum_acc;
		logic chk;
		logic mod_step;
		logic cur_load;
		logic pct_load;
		logic div_step;
		logic emit;
		logic empty_emit;
		logic head_sub;
	} wrpb_cmd_t;

	// status from the datapath back to the controller
	typedef struct packed {
		logic fill_zero;
		logic sum_last;
		logic total_zero;
		logic mod_ge;
		logic div_last;
		logic slot_last;
		logic head_wrap2;
		logic head_ge;
	} wrpb_sts_t;

endpackage

/* rtl/weight_ring_percent_balancer.sv */
// Weight ring percent balancer, top level: APB register, controller, datapath.
// Depends on wrpb_pkg, wrpb_ctrl, wrpb_dp (and wrpb_ram through it).
//
// A beat on the request side is taken at a rising edge with start high and busy
// low. A push (req_type 0) leaves busy low, so pushes go back to back. Only
// when ring_limit was lowered so far that head + 1 reaches twice the ring length
// does a push leave the head at or above the ring length; busy then stays high
// while the head is brought back into range, one ring length at a time. A
// balance (req_type 1) holds busy while it reads, then adds, each filled entry
// on the single read port of the weight RAM, runs a check step, wraps the
// cursor with at most one subtraction (the fill never shrinks, so the old cursor
// is always below the new slot count), then for each reported slot reads,
// multiplies by 100, runs the bit-serial divider and emits. An empty ring skips
// the sum. A zero total gives one beat with empty_total set and changes nothing.
// Result beats are shown for exactly one cycle with result_strobe high; the
// receiver cannot stall them, so it must take every strobed cycle. The last beat
// of a balance shows in the first cycle after busy falls. Weight entries reset
// to zero through per-entry valid bits, so no clearing pass follows reset.
// ring_limit at byte address 0 may be written only while busy is low and no
// result beat is pending.
module weight_ring_percent_balancer #(
	parameter int STORE_DEPTH = 64,
	parameter int BAR_SLOTS   = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	// requests
	input  logic                          start,
	output logic                          busy,
	input  logic                          req_type,
	input  logic [31:0]                   entry_id,
	input  logic [wrpb_pkg::W_WEIGHT-1:0] entry_weight,
	// results
	output logic                          result_strobe,
	output logic [wrpb_pkg::W_SLOT-1:0]   slot_index,
	output logic [wrpb_pkg::W_PCT-1:0]    percent,
	output logic [wrpb_pkg::W_CUR-1:0]    cursor_now,
	output logic                          empty_total,
	output logic                          last
);
	import wrpb_pkg::*;

	logic [W_LIMIT-1:0] limit_q;
	logic               acc_c;
	logic               cfg_wr;
	wrpb_cmd_t          cmd;
	wrpb_sts_t          sts;
	logic               busy_c;

	// register 0 lives at byte address 0; paddr[2] set selects nothing
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready & ~paddr[2];
	assign prdata = paddr[2] ? 32'd0 : 32'(limit_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= '0;
		end else if (cfg_wr) begin
			limit_q <= pwdata[W_LIMIT-1:0];
		end
	end

	// entry_id: no request reads identifiers back, so they are not kept
	assign acc_c = start & ~busy_c;
	assign busy  = busy_c;

	wrpb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (acc_c),
		.req_type (req_type),
		.busy     (busy_c),
		.cmd      (cmd),
		.sts      (sts)
	);

	wrpb_dp #(
		.STORE_DEPTH (STORE_DEPTH),
		.BAR_SLOTS   (BAR_SLOTS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.ring_limit    (limit_q),
		.entry_weight  (entry_weight),
		.slot_index    (slot_index),
		.percent       (percent),
		.cursor_now    (cursor_now),
		.empty_total   (empty_total),
		.last          (last),
		.result_strobe (result_strobe)
	);

endmodule

/* rtl/wrpb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wrpb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/wrpb_ctrl.sv */
// Controller FSM for the balancer: sequences push, sum, cursor, divide, emit.
// Depends on wrpb_pkg.
module wrpb_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                req_type,
	output logic                busy,
	output wrpb_pkg::wrpb_cmd_t cmd,
	input  wrpb_pkg::wrpb_sts_t sts
);
	import wrpb_pkg::*;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_SUM_RD  = 4'd1;
	localparam logic [3:0] S_SUM_ACC = 4'd2;
	localparam logic [3:0] S_CHECK   = 4'd3;
	localparam logic [3:0] S_MOD     = 4'd4;
	localparam logic [3:0] S_PCT_RD  = 4'd5;
	localparam logic [3:0] S_PCT_MUL = 4'd6;
	localparam logic [3:0] S_DIV     = 4'd7;
	localparam logic [3:0] S_EMIT    = 4'd8;
	localparam logic [3:0] S_EMPTY   = 4'd9;
	localparam logic [3:0] S_HFIX    = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_nx;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (req_type) begin
						cmd.bal_init = 1'b1;
						state_nx     = sts.fill_zero ? S_CHECK : S_SUM_RD;
					end else begin
						cmd.push = 1'b1;
						if (sts.head_wrap2) begin
							state_nx = S_HFIX;
						end
					end
				end
			end
			S_SUM_RD: begin
				state_nx = S_SUM_ACC;
			end
			S_SUM_ACC: begin
				cmd.sum_acc = 1'b1;
				state_nx    = sts.sum_last ? S_CHECK : S_SUM_RD;
			end
			S_CHECK: begin
				cmd.chk  = 1'b1;
				state_nx = sts.total_zero ? S_EMPTY : S_MOD;
			end
			S_MOD: begin
				if (sts.mod_ge) begin
					cmd.mod_step = 1'b1;
				end else begin
					cmd.cur_load = 1'b1;
					state_nx     = S_PCT_RD;
				end
			end
			S_PCT_RD: begin
				state_nx = S_PCT_MUL;
			end
			S_PCT_MUL: begin
				cmd.pct_load = 1'b1;
				state_nx     = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_nx = S_EMIT;
				end
			end
			S_EMIT: begin
				cmd.emit = 1'b1;
				state_nx = sts.slot_last ? S_IDLE : S_PCT_RD;
			end
			S_EMPTY: begin
				cmd.empty_emit = 1'b1;
				state_nx       = S_IDLE;
			end
			S_HFIX: begin
				if (sts.head_ge) begin
					cmd.head_sub = 1'b1;
				end else begin
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

/* rtl/wrpb_dp.sv */
// Datapath: weight ring, valid bits, total, cursor modulo, restoring divider.
// Depends on wrpb_pkg and wrpb_ram.
module wrpb_dp #(
	parameter int STORE_DEPTH = 64,
	parameter int BAR_SLOTS   = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  wrpb_pkg::wrpb_cmd_t                cmd,
	output wrpb_pkg::wrpb_sts_t                sts,
	input  logic [wrpb_pkg::W_LIMIT-1:0]       ring_limit,
	input  logic [wrpb_pkg::W_WEIGHT-1:0]      entry_weight,
	output logic [wrpb_pkg::W_SLOT-1:0]        slot_index,
	output logic [wrpb_pkg::W_PCT-1:0]         percent,
	output logic [wrpb_pkg::W_CUR-1:0]         cursor_now,
	output logic                               empty_total,
	output logic                               last,
	output logic                               result_strobe
);
	import wrpb_pkg::*;

	localparam int IDX_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
	localparam int SUM_W  = W_WEIGHT + $clog2(STORE_DEPTH);
	localparam int BC_W   = $clog2(BAR_SLOTS + 1);
	localparam int CUR_W  = (BAR_SLOTS > 1) ? $clog2(BAR_SLOTS) : 1;
	localparam int PROD_W = W_WEIGHT + W_PCT;
	localparam int DIV_W  = (SUM_W + W_PCT - 1 > PROD_W) ? SUM_W + W_PCT - 1 : PROD_W;
	localparam int K_W    = $clog2(W_PCT);

	logic [CNT_W-1:0]       len_c;
	logic [CNT_W:0]         h1_c;
	logic [CNT_W:0]         len1_c;
	logic [CNT_W:0]         len2_c;
	logic [IDX_W-1:0]       head_nx_c;
	logic [IDX_W-1:0]       head_q;
	logic [CNT_W-1:0]       fill_q;
	logic [STORE_DEPTH-1:0] valid_q;
	logic [CUR_W-1:0]       cur_q;

	logic [CNT_W-1:0]       idx_q;
	logic [SUM_W-1:0]       total_q;
	logic [W_WEIGHT-1:0]    rd_data;
	logic                   rd_vld_q;
	logic [W_WEIGHT-1:0]    wt_c;
	logic [PROD_W-1:0]      prod_c;
	logic [CNT_W-1:0]       slots_q;
	logic [BC_W-1:0]        mod_q;
	logic [DIV_W-1:0]       rem_q;
	logic [DIV_W-1:0]       dsh_q;
	logic [W_PCT-1:0]       quo_q;
	logic [K_W-1:0]         k_q;

	// ring length in use
	always_comb begin
		if ((ring_limit == '0) || (int'(ring_limit) > STORE_DEPTH)) begin
			len_c = CNT_W'(STORE_DEPTH);
		end else begin
			len_c = CNT_W'(ring_limit);
		end
	end

	assign h1_c      = (CNT_W + 1)'(head_q) + (CNT_W + 1)'(1);
	assign len1_c    = (CNT_W + 1)'(len_c);
	assign len2_c    = {len_c, 1'b0};
	assign head_nx_c = (h1_c >= len1_c) ? IDX_W'(h1_c - len1_c) : IDX_W'(h1_c);

	assign wt_c   = rd_vld_q ? rd_data : '0;
	assign prod_c = PROD_W'(wt_c) * PROD_W'(PCT_SCALE);

	assign sts.fill_zero  = (fill_q == '0);
	assign sts.sum_last   = (idx_q == fill_q - CNT_W'(1));
	assign sts.total_zero = (total_q == '0);
	assign sts.mod_ge     = (mod_q >= BC_W'(slots_q));
	assign sts.div_last   = (k_q == '0);
	assign sts.slot_last  = (idx_q == slots_q - CNT_W'(1));
	assign sts.head_wrap2 = (h1_c >= len2_c);
	assign sts.head_ge    = (CNT_W'(head_q) >= len_c);

	wrpb_ram #(
		.WIDTH (W_WEIGHT),
		.DEPTH (STORE_DEPTH)
	) u_wt_ram (
		.clk   (clk),
		.we    (cmd.push),
		.waddr (head_q),
		.wdata (entry_weight),
		.raddr (idx_q[IDX_W-1:0]),
		.rdata (rd_data)
	);

	// ring pointers, valid bits, cursor, result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q        <= '0;
			fill_q        <= '0;
			valid_q       <= '0;
			cur_q         <= '0;
			result_strobe <= 1'b0;
		end else begin
			result_strobe <= cmd.emit | cmd.empty_emit;
			if (cmd.push) begin
				valid_q[head_q] <= 1'b1;
				head_q          <= head_nx_c;
				if (fill_q < len_c) begin
					fill_q <= fill_q + CNT_W'(1);
				end
			end
			if (cmd.head_sub) begin
				head_q <= head_q - IDX_W'(len_c);
			end
			if (cmd.cur_load) begin
				cur_q <= CUR_W'(mod_q);
			end
		end
	end

	// working registers of a balance
	always_ff @(posedge clk) begin
		rd_vld_q <= valid_q[idx_q[IDX_W-1:0]];
		if (cmd.bal_init) begin
			idx_q   <= '0;
			total_q <= '0;
		end
		if (cmd.sum_acc) begin
			total_q <= total_q + SUM_W'(wt_c);
			idx_q   <= idx_q + CNT_W'(1);
		end
		if (cmd.chk) begin
			idx_q <= '0;
			mod_q <= BC_W'(cur_q) + BC_W'(1);
			if (int'(fill_q) < BAR_SLOTS) begin
				slots_q <= fill_q;
			end else begin
				slots_q <= CNT_W'(BAR_SLOTS);
			end
		end
		if (cmd.mod_step) begin
			mod_q <= mod_q - BC_W'(slots_q);
		end
		if (cmd.pct_load) begin
			rem_q <= DIV_W'(prod_c);
			dsh_q <= DIV_W'(total_q) << (W_PCT - 1);
			quo_q <= '0;
			k_q   <= K_W'(W_PCT - 1);
		end
		if (cmd.div_step) begin
			if (rem_q >= dsh_q) begin
				rem_q <= rem_q - dsh_q;
				quo_q <= {quo_q[W_PCT-2:0], 1'b1};
			end else begin
				quo_q <= {quo_q[W_PCT-2:0], 1'b0};
			end
			dsh_q <= dsh_q >> 1;
			k_q   <= k_q - K_W'(1);
		end
		if (cmd.emit) begin
			slot_index  <= W_SLOT'(idx_q);
			percent     <= quo_q;
			cursor_now  <= W_CUR'(cur_q);
			empty_total <= 1'b0;
			last        <= sts.slot_last;
			idx_q       <= idx_q + CNT_W'(1);
		end
		if (cmd.empty_emit) begin
			slot_index  <= '0;
			percent     <= '0;
			cursor_now  <= W_CUR'(cur_q);
			empty_total <= 1'b1;
			last        <= 1'b1;
		end
	end

endmodule
